// ===== sv/lattice_flux_tensor_closure_assert.svh =====
// Assertion macros used by the checker module.
`ifndef LATTICE_FLUX_TENSOR_CLOSURE_ASSERT_SVH
`define LATTICE_FLUX_TENSOR_CLOSURE_ASSERT_SVH

// Property must hold at every clock edge out of reset.
`define LFTC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("lftc assertion failed");

// Condition must never be seen at a clock edge out of reset.
`define LFTC_DENY(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) \
    else $error("lftc forbidden condition seen");

`endif

// ===== sv/lftc_pkg.sv =====
package lftc_pkg;

  localparam int MAX_PADDED_ROW_DEF = 1024;
  localparam int FRACTION_BITS_DEF  = 24;

  localparam int COL_W = 10;
  localparam int ROW_W = 16;

  typedef struct packed {
    logic        [30:0] density;
    logic signed [31:0] x_momentum;
    logic signed [31:0] y_momentum;
  } lftc_in_t;

  typedef struct packed {
    logic signed [31:0] flux_xx;
    logic signed [31:0] flux_xy;
    logic signed [31:0] flux_yy;
    logic               zero_density;
    logic               last_cell;
  } lftc_out_t;

  typedef struct packed {
    logic [31:0]      relax_time;
    logic             linear_closure;
    logic [COL_W-1:0] row_length;
    logic [ROW_W-1:0] row_count;
  } lftc_cfg_t;

  // One classified cell handed from the front to the back.
  typedef struct packed {
    lftc_in_t         item;
    logic [COL_W-1:0] col;
    logic             par;
    logic             has_res;
    logic             last;
  } lftc_job_t;

  typedef enum logic [3:0] {
    REG_RELAX_TIME     = 4'd0,
    REG_LINEAR_CLOSURE = 4'd1,
    REG_ROW_LENGTH     = 4'd2,
    REG_ROW_COUNT      = 4'd3
  } lftc_reg_e;

  typedef enum logic [3:0] {
    B_IDLE,
    B_DVX_GO,
    B_DVX_WT,
    B_DVY_GO,
    B_DVY_WT,
    B_WB,
    B_RD,
    B_DIFF,
    B_MUL,
    B_FIN,
    B_OUT
  } lftc_back_e;

  typedef enum logic [3:0] {
    STEP_TR,
    STEP_K,
    STEP_VXX,
    STEP_VXY,
    STEP_VYY,
    STEP_UXX,
    STEP_XXP,
    STEP_UYY,
    STEP_YYP,
    STEP_RUX,
    STEP_XYP
  } lftc_step_e;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic fits;
    fits = (&v[65:31]) | ~(|v[65:31]);
    if (fits) begin
      return v[31:0];
    end else if (v[65]) begin
      return 32'sh80000000;
    end else begin
      return 32'sh7FFFFFFF;
    end
  endfunction

endpackage

// ===== sv/lftc_queue.sv =====
module lftc_queue
  import lftc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  lftc_job_t data_i,
  input  logic      pop_i,
  output logic      full_o,
  output logic      valid_o,
  output lftc_job_t data_o
);

  lftc_job_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== sv/lftc_front.sv =====
module lftc_front
  import lftc_pkg::*;
#(
  parameter int MAX_PADDED_ROW = MAX_PADDED_ROW_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  lftc_in_t  in_item_i,
  input  lftc_cfg_t cfg_i,
  input  logic      full_i,
  output logic      push_o,
  output lftc_job_t job_o
);

  localparam int LenMax = MAX_PADDED_ROW - 2;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W:0]   len_c, wid, col_x;
  logic [ROW_W-1:0] cnt_c;
  logic [ROW_W:0]   hgt, row_x;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i & ~full_i;
  assign col_x      = {1'b0, col_q};
  assign row_x      = {1'b0, row_q};

  always_comb begin
    if (cfg_i.row_length == '0) begin
      len_c = (COL_W+1)'(1);
    end else if (int'(cfg_i.row_length) > LenMax) begin
      len_c = (COL_W+1)'(LenMax);
    end else begin
      len_c = {1'b0, cfg_i.row_length};
    end
    if (cfg_i.row_count == '0) begin
      cnt_c = ROW_W'(1);
    end else if (&cfg_i.row_count) begin
      cnt_c = cfg_i.row_count - ROW_W'(1);
    end else begin
      cnt_c = cfg_i.row_count;
    end
    wid = len_c + (COL_W+1)'(2);
    hgt = {1'b0, cnt_c} + (ROW_W+1)'(2);
  end

  always_comb begin
    job_o.item    = in_item_i;
    job_o.col     = col_q;
    job_o.par     = row_q[0];
    job_o.has_res = (row_q >= ROW_W'(2)) && (col_q != '0) &&
                    (col_x + (COL_W+1)'(2) <= wid);
    job_o.last    = (row_x == hgt - (ROW_W+1)'(1)) && (col_x == wid - (COL_W+1)'(2));
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (push_o) begin
      if (col_x + (COL_W+1)'(1) >= wid) begin
        col_d = '0;
        row_d = (row_x + (ROW_W+1)'(1) >= hgt) ? '0 : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== sv/lftc_div.sv =====
module lftc_div
  import lftc_pkg::*;
#(
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] mom_i,
  input  logic        [30:0] rho_i,
  output logic               done_o,
  output logic signed [31:0] vel_o
);

  localparam int NB   = 32 + FRACTION_BITS;
  localparam int CNTW = $clog2(NB + 1);

  logic            busy_q;
  logic [CNTW-1:0] cnt_q;
  logic [NB-1:0]   num_q, quo_q;
  logic [30:0]     rem_q, div_q;
  logic            neg_q;
  logic [31:0]     mag, trial;
  logic            take, over_pos, over_neg;

  assign mag   = mom_i[31] ? (~mom_i + 32'd1) : mom_i;
  assign trial = {rem_q, num_q[NB-1]};
  assign take  = trial >= {1'b0, div_q};

  assign done_o   = busy_q && (cnt_q == '0);
  assign over_pos = |quo_q[NB-1:31];
  assign over_neg = (|quo_q[NB-1:32]) || (quo_q[31] && (|quo_q[30:0]));

  always_comb begin
    if (neg_q) begin
      vel_o = over_neg ? 32'sh80000000 : -$signed(quo_q[31:0]);
    end else begin
      vel_o = over_pos ? 32'sh7FFFFFFF : $signed(quo_q[31:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= (rho_i == '0) ? '0 : CNTW'(NB);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CNTW'(1);
      end
    end
  end

  // Restoring divide, one quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= NB'(mag) << FRACTION_BITS;
      quo_q <= '0;
      rem_q <= '0;
      div_q <= rho_i;
      neg_q <= mom_i[31];
    end else if (busy_q && cnt_q != '0) begin
      num_q <= num_q << 1;
      quo_q <= {quo_q[NB-2:0], take};
      rem_q <= take ? 31'(trial - {1'b0, div_q}) : trial[30:0];
    end
  end

endmodule

// ===== sv/lftc_back.sv =====
module lftc_back
  import lftc_pkg::*;
#(
  parameter int MAX_PADDED_ROW = MAX_PADDED_ROW_DEF,
  parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  input  lftc_job_t job_i,
  output logic      pop_o,
  input  lftc_cfg_t cfg_i,
  output logic      out_valid_o,
  output lftc_out_t out_item_o,
  input  logic      out_stall_i
);

  localparam int CW = $clog2(MAX_PADDED_ROW);
  localparam int AW = CW + 1;
  localparam longint OneThirdL  = ((longint'(1) << FRACTION_BITS) + 1) / 3;
  localparam longint TwoThirdsL = ((longint'(2) << FRACTION_BITS) + 1) / 3;
  localparam logic signed [32:0] OneThird  = 33'(OneThirdL);
  localparam logic signed [32:0] TwoThirds = 33'(TwoThirdsL);
  localparam logic signed [65:0] Half      = 66'(longint'(1) << (FRACTION_BITS - 1));

  typedef struct packed {
    logic               flag;
    logic signed [31:0] vy;
    logic signed [31:0] vx;
  } vel_t;

  lftc_back_e state_q, state_d;
  lftc_step_e step_q;

  lftc_job_t job_q;
  logic signed [31:0] vx_q, vy_q;
  vel_t  vmem [2**AW];
  logic [30:0] dmem [2**CW];
  vel_t  rd_q, n_q, w_q, e_q, c_q;
  logic [30:0] rho_q;
  logic [2:0]  rcnt_q;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [CW-1:0] col_c;

  logic signed [31:0] sxx_q, sxy_q, syy_q;
  logic               zero_q, zero_c;
  logic signed [33:0] dxx, dyy;
  logic signed [34:0] dxy;

  logic signed [65:0] prod_q;
  logic signed [32:0] opa, opb;
  logic signed [31:0] mres, t_plus;
  logic signed [31:0] tr_q, k_q, vxx_q, vxy_q, vyy_q, t_q, pxx_q, pxy_q, pyy_q;

  logic      div_start, div_done;
  logic signed [31:0] div_vel, div_mom;
  logic      mem_we, out_load, out_free, last_step;
  logic      out_valid_q;
  lftc_out_t out_q;

  lftc_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .mom_i  (div_mom),
    .rho_i  (job_q.item.density),
    .done_o (div_done),
    .vel_o  (div_vel)
  );

  function automatic logic signed [31:0] mq_fin(input logic signed [65:0] p);
    logic signed [65:0] s;
    s = (p + Half) >>> FRACTION_BITS;
    return sat32(s);
  endfunction

  assign col_c       = CW'(job_q.col);
  assign wr_addr     = {job_q.par, col_c};
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign last_step   = (step_q == STEP_XYP) || (step_q == STEP_UXX && cfg_i.linear_closure);

  // Stencil: north is two rows up (the slot about to be overwritten),
  // west/east/center come from the previous row.
  always_comb begin
    dxx = 34'(e_q.vx) - 34'(w_q.vx);
    dyy = 34'(vy_q) - 34'(n_q.vy);
    dxy = (35'(vx_q) - 35'(n_q.vx)) + (35'(e_q.vy) - 35'(w_q.vy));
    zero_c = (job_q.item.density == '0) | n_q.flag | w_q.flag | e_q.flag | (rho_q == '0);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:   if (job_valid_i) state_d = B_DVX_GO;
      B_DVX_GO: state_d = B_DVX_WT;
      B_DVX_WT: if (div_done) state_d = B_DVY_GO;
      B_DVY_GO: state_d = B_DVY_WT;
      B_DVY_WT: if (div_done) state_d = job_q.has_res ? B_RD : B_WB;
      B_WB:     state_d = B_IDLE;
      B_RD:     if (rcnt_q == 3'd4) state_d = B_DIFF;
      B_DIFF:   state_d = zero_c ? B_OUT : B_MUL;
      B_MUL:    state_d = B_FIN;
      B_FIN:    state_d = last_step ? B_OUT : B_MUL;
      B_OUT:    if (out_free) state_d = B_IDLE;
      default:  state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o     = (state_q == B_IDLE) && job_valid_i;
    div_start = (state_q == B_DVX_GO) || (state_q == B_DVY_GO);
    div_mom   = (state_q == B_DVX_GO) ? job_q.item.x_momentum : job_q.item.y_momentum;
    out_load  = (state_q == B_OUT) && out_free;
    mem_we    = (state_q == B_WB) || out_load;
  end

  always_comb begin
    case (rcnt_q)
      3'd0:    rd_addr = {job_q.par, col_c};
      3'd1:    rd_addr = {~job_q.par, col_c - CW'(1)};
      3'd2:    rd_addr = {~job_q.par, col_c + CW'(1)};
      default: rd_addr = {~job_q.par, col_c};
    endcase
  end

  always_comb begin
    case (step_q)
      STEP_TR:  begin opa = {1'b0, cfg_i.relax_time}; opb = {2'b00, rho_q}; end
      STEP_K:   begin opa = TwoThirds; opb = 33'(tr_q); end
      STEP_VXX: begin opa = 33'(k_q); opb = 33'(sxx_q); end
      STEP_VXY: begin opa = 33'(k_q); opb = 33'(sxy_q); end
      STEP_VYY: begin opa = 33'(k_q); opb = 33'(syy_q); end
      STEP_UXX: begin
        if (cfg_i.linear_closure) begin
          opa = OneThird; opb = {2'b00, rho_q};
        end else begin
          opa = 33'(c_q.vx); opb = 33'(c_q.vx);
        end
      end
      STEP_XXP: begin opa = {2'b00, rho_q}; opb = 33'(t_q); end
      STEP_UYY: begin opa = 33'(c_q.vy); opb = 33'(c_q.vy); end
      STEP_YYP: begin opa = {2'b00, rho_q}; opb = 33'(t_q); end
      STEP_RUX: begin opa = {2'b00, rho_q}; opb = 33'(c_q.vx); end
      STEP_XYP: begin opa = 33'(t_q); opb = 33'(c_q.vy); end
      default:  begin opa = '0; opb = '0; end
    endcase
    mres   = mq_fin(prod_q);
    t_plus = sat32(66'(OneThird) + 66'(mres));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      vmem[wr_addr] <= '{flag: job_q.item.density == '0, vy: vy_q, vx: vx_q};
      dmem[col_c]   <= job_q.item.density;
    end
    if (state_q == B_RD) begin
      rd_q <= vmem[rd_addr];
      if (rcnt_q == 3'd0) begin
        rho_q <= dmem[col_c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (state_q == B_DVX_WT && div_done) begin
      vx_q <= div_vel;
    end
    if (state_q == B_DVY_WT && div_done) begin
      vy_q   <= div_vel;
      rcnt_q <= 3'd0;
    end
    if (state_q == B_RD) begin
      rcnt_q <= rcnt_q + 3'd1;
      case (rcnt_q)
        3'd1:    n_q <= rd_q;
        3'd2:    w_q <= rd_q;
        3'd3:    e_q <= rd_q;
        3'd4:    c_q <= rd_q;
        default: ;
      endcase
    end
    if (state_q == B_DIFF) begin
      sxx_q  <= 32'(dxx >>> 1);
      syy_q  <= 32'(dyy >>> 1);
      sxy_q  <= 32'(dxy >>> 2);
      zero_q <= zero_c;
      step_q <= STEP_TR;
    end
    if (state_q == B_MUL) begin
      prod_q <= opa * opb;
    end
    if (state_q == B_FIN) begin
      step_q <= lftc_step_e'(step_q + 4'd1);
      case (step_q)
        STEP_TR:  tr_q  <= mres;
        STEP_K:   k_q   <= mres;
        STEP_VXX: vxx_q <= mres;
        STEP_VXY: vxy_q <= mres;
        STEP_VYY: vyy_q <= mres;
        STEP_UXX: begin
          if (cfg_i.linear_closure) begin
            pxx_q <= mres;
            pyy_q <= mres;
            pxy_q <= '0;
          end else begin
            t_q <= t_plus;
          end
        end
        STEP_XXP: pxx_q <= mres;
        STEP_UYY: t_q   <= t_plus;
        STEP_YYP: pyy_q <= mres;
        STEP_RUX: t_q   <= mres;
        STEP_XYP: pxy_q <= mres;
        default:  ;
      endcase
    end
    if (out_load) begin
      out_q.flux_xx      <= zero_q ? 32'sh7FFFFFFF : sat32(66'(pxx_q) - 66'(vxx_q));
      out_q.flux_xy      <= zero_q ? 32'sh7FFFFFFF : sat32(66'(pxy_q) - 66'(vxy_q));
      out_q.flux_yy      <= zero_q ? 32'sh7FFFFFFF : sat32(66'(pyy_q) - 66'(vyy_q));
      out_q.zero_density <= zero_q;
      out_q.last_cell    <= job_q.last;
    end
  end

endmodule

// ===== sv/lattice_flux_tensor_closure.sv =====
// Momentum flux closure for a 2D lattice grid streamed in raster order with a
// one-cell ghost border. A two-entry queue decouples the input side from the
// engine, so up to two cells are taken ahead while the engine works. Each cell
// runs the bit-serial velocity divider once per axis; a cell that yields a
// flux result also needs the line-buffer reads on the single memory port and
// eleven passes through the shared multiplier (six passes in linear mode, none
// when a stencil cell has zero density). A result waits in the output register
// and stalls the engine only once the next result is ready.
module lattice_flux_tensor_closure
  import lftc_pkg::*;
#(
  parameter int MAX_PADDED_ROW = MAX_PADDED_ROW_DEF,
  parameter int FRACTION_BITS  = FRACTION_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  lftc_in_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output lftc_out_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  lftc_cfg_t cfg_q;
  lftc_job_t job_push, job_head;
  logic      push, pop, full, head_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.relax_time     <= 32'h0100_0000;
      cfg_q.linear_closure <= 1'b0;
      cfg_q.row_length     <= COL_W'(1022);
      cfg_q.row_count      <= ROW_W'(1022);
    end else if (cfg_valid_i) begin
      unique case (lftc_reg_e'(cfg_index_i))
        REG_RELAX_TIME:     cfg_q.relax_time     <= cfg_data_i;
        REG_LINEAR_CLOSURE: cfg_q.linear_closure <= cfg_data_i[0];
        REG_ROW_LENGTH:     cfg_q.row_length     <= cfg_data_i[COL_W-1:0];
        REG_ROW_COUNT:      cfg_q.row_count      <= cfg_data_i[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  lftc_front #(
    .MAX_PADDED_ROW(MAX_PADDED_ROW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i (in_item_i),
    .cfg_i     (cfg_q),
    .full_i    (full),
    .push_o    (push),
    .job_o     (job_push)
  );

  lftc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (job_push),
    .pop_i  (pop),
    .full_o (full),
    .valid_o(head_valid),
    .data_o (job_head)
  );

  lftc_back #(
    .MAX_PADDED_ROW(MAX_PADDED_ROW),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(head_valid),
    .job_i      (job_head),
    .pop_o      (pop),
    .cfg_i      (cfg_q),
    .out_valid_o(out_valid_o),
    .out_item_o (out_item_o),
    .out_stall_i(out_stall_i)
  );

endmodule

// ===== sv/lftc_checker.sv =====
`include "lattice_flux_tensor_closure_assert.svh"

module lftc_checker
  import lftc_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input lftc_in_t  in_item_i,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input lftc_out_t out_item_o,
  input logic      cfg_ready_o
);

  `LFTC_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
  `LFTC_ASSERT(a_in_hold, in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
  `LFTC_ASSERT(a_zero_sat, out_valid_o && out_item_o.zero_density |-> out_item_o.flux_xx == 32'sh7FFFFFFF && out_item_o.flux_xy == 32'sh7FFFFFFF && out_item_o.flux_yy == 32'sh7FFFFFFF)
  `LFTC_DENY(a_cfg_ready, !cfg_ready_o)

endmodule

bind lattice_flux_tensor_closure lftc_checker u_checker (.*);

// ===== test/tb.sv =====
module tb;
  import lftc_pkg::*;

  localparam int QUIET_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 300;

  // Tracks the closure's line buffers and configuration and keeps the flux
  // results still owed by the block.
  class flux_tracker;
    int unsigned tau;
    bit          linear;
    bit [9:0]    len_reg;
    bit [15:0]   cnt_reg;
    int          vel_x[2048];
    int          vel_y[2048];
    bit          zflag[2048];
    longint      dens_row[1024];
    int unsigned col, row;
    lftc_out_t   expected_flux[$];
    int          errors;
    int          results;

    function new();
      tau = 32'h0100_0000;
      linear = 0;
      len_reg = 10'd1022;
      cnt_reg = 16'd1022;
      col = 0;
      row = 0;
      errors = 0;
      results = 0;
    endfunction

    function void write_reg(lftc_reg_e idx, logic [31:0] d);
      case (idx)
        REG_RELAX_TIME: tau = d;
        REG_LINEAR_CLOSURE: linear = d[0];
        REG_ROW_LENGTH: len_reg = d[9:0];
        REG_ROW_COUNT: cnt_reg = d[15:0];
        default: ;
      endcase
    endfunction

    function longint clip(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function longint qmul(longint a, longint b);
      longint p;
      p = a * b + (64'sd1 <<< 23);
      return clip(p >>> 24);
    endfunction

    function int speed(longint m, longint rho);
      longint mag, q;
      if (rho == 0) return 0;
      mag = (m < 0) ? -m : m;
      q = (mag <<< 24) / rho;
      if (m < 0) return (q > 64'sd2147483648) ? 32'sh8000_0000 : int'(-q);
      return (q > 64'sd2147483647) ? 32'sh7FFF_FFFF : int'(q);
    endfunction

    function void note_input(lftc_in_t c);
      longint rho_in, mx, my, rho, ux, uy, dxx, dyy, dxy, sxx, syy, sxy;
      longint tr, k, vxx, vxy, vyy, iso, fxx, fxy, fyy;
      longint unsigned trw;
      int unsigned len, cnt, w, h, cur, prv, nth, wst, est, ctr;
      int vx, vy;
      bit zin, zero;
      lftc_out_t r;
      rho_in = c.density;
      mx = c.x_momentum;
      my = c.y_momentum;
      len = len_reg;
      cnt = cnt_reg;
      if (len < 1) len = 1;
      if (len > 1022) len = 1022;
      if (cnt < 1) cnt = 1;
      if (cnt > 65534) cnt = 65534;
      w = len + 2;
      h = cnt + 2;
      cur = (row & 1) * 1024;
      prv = ((row + 1) & 1) * 1024;
      zin = (rho_in == 0);
      vx = speed(mx, rho_in);
      vy = speed(my, rho_in);
      if (row >= 2 && col >= 1 && col + 2 <= w) begin
        nth = cur + col;
        wst = prv + col - 1;
        est = prv + col + 1;
        ctr = prv + col;
        rho = dens_row[col];
        ux = vel_x[ctr];
        uy = vel_y[ctr];
        zero = zin || zflag[nth] || zflag[wst] || zflag[est] || rho == 0;
        if (zero) begin
          fxx = 64'sd2147483647;
          fxy = fxx;
          fyy = fxx;
        end else begin
          dxx = longint'(vel_x[est]) - vel_x[wst];
          dyy = longint'(vy) - vel_y[nth];
          dxy = (longint'(vx) - vel_x[nth]) + (longint'(vel_y[est]) - vel_y[wst]);
          sxx = dxx >>> 1;
          syy = dyy >>> 1;
          sxy = dxy >>> 2;
          trw = (64'(tau) * 64'(rho) + 64'd8388608) >> 24;
          tr = (trw > 64'd2147483647) ? 64'sd2147483647 : longint'(trw);
          k = qmul(64'sd11184811, tr);
          vxx = qmul(k, sxx);
          vxy = qmul(k, sxy);
          vyy = qmul(k, syy);
          if (linear) begin
            iso = qmul(64'sd5592405, rho);
            fxx = clip(iso - vxx);
            fxy = clip(-vxy);
            fyy = clip(iso - vyy);
          end else begin
            fxx = clip(qmul(rho, clip(64'sd5592405 + qmul(ux, ux))) - vxx);
            fxy = clip(qmul(qmul(rho, ux), uy) - vxy);
            fyy = clip(qmul(rho, clip(64'sd5592405 + qmul(uy, uy))) - vyy);
          end
        end
        r.flux_xx = fxx[31:0];
        r.flux_xy = fxy[31:0];
        r.flux_yy = fyy[31:0];
        r.zero_density = zero;
        r.last_cell = (row == h - 1) && (col == w - 2);
        expected_flux.push_back(r);
      end
      vel_x[cur + col] = vx;
      vel_y[cur + col] = vy;
      zflag[cur + col] = zin;
      dens_row[col] = rho_in;
      if (col + 1 >= w) begin
        col = 0;
        row = (row + 1 >= h) ? 0 : row + 1;
      end else begin
        col = col + 1;
      end
    endfunction

    function void check_result(lftc_out_t got);
      lftc_out_t want;
      results++;
      if (expected_flux.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected flux item %h", got);
        return;
      end
      want = expected_flux.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("flux mismatch: exp xx=%h xy=%h yy=%h z=%b l=%b got xx=%h xy=%h yy=%h z=%b l=%b",
                   want.flux_xx, want.flux_xy, want.flux_yy, want.zero_density, want.last_cell,
                   got.flux_xx, got.flux_xy, got.flux_yy, got.zero_density, got.last_cell);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  lftc_in_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  lftc_out_t   out_item_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [3:0]  cfg_index_i = REG_RELAX_TIME;
  logic [31:0] cfg_data_i = '0;

  flux_tracker tracker = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;
  int cells_sent = 0;

  lattice_flux_tensor_closure dut (.*);

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) tracker.note_input(in_item_i);
      if (out_valid_o && !out_stall_i) tracker.check_result(out_item_o);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("tb failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  always @(posedge clk_i) out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);

  task automatic write_reg(lftc_reg_e idx, logic [31:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(idx, d);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every owed result is back, then lets the engine finish the
  // trailing ghost cells before anything is reconfigured.
  task automatic drain();
    while (tracker.expected_flux.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_cells(ref lftc_in_t cells[$]);
    foreach (cells[i]) begin
      if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
        in_valid_i <= 1'b0;
        do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
      end
      in_valid_i <= 1'b1;
      in_item_i <= cells[i];
      do @(posedge clk_i); while (in_stall_o);
      cells_sent++;
    end
    in_valid_i <= 1'b0;
  endtask

  function automatic lftc_in_t rand_cell();
    lftc_in_t c;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) c.density = '0;
    else if (pick < 20) c.density = 31'($urandom());
    else if (pick < 24) c.density = 31'h7FFF_FFFF;
    else c.density = 31'(32'h0080_0000 + $urandom_range(0, 32'h0100_0000));
    if ($urandom_range(0, 4) == 0) begin
      c.x_momentum = $urandom();
      c.y_momentum = $urandom();
    end else begin
      c.x_momentum = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
      c.y_momentum = $signed($urandom_range(0, 32'h0100_0000)) - 32'sh0080_0000;
    end
    return c;
  endfunction

  task automatic random_grid(int len_cfg, int cnt_cfg);
    lftc_in_t cells[$];
    int w, h;
    w = (len_cfg < 1 ? 1 : (len_cfg > 1022 ? 1022 : len_cfg)) + 2;
    h = (cnt_cfg < 1 ? 1 : cnt_cfg) + 2;
    write_reg(REG_ROW_LENGTH, len_cfg);
    write_reg(REG_ROW_COUNT, cnt_cfg);
    repeat (w * h) cells.push_back(rand_cell());
    send_cells(cells);
    drain();
  endtask

  initial begin
    lftc_in_t cells[$];
    int grid;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single interior cell with a maximum-density center, a saturating west neighbour and maximum tau.
    write_reg(REG_RELAX_TIME, 32'hFFFF_FFFF);
    write_reg(REG_LINEAR_CLOSURE, 0);
    write_reg(REG_ROW_LENGTH, 1);
    write_reg(REG_ROW_COUNT, 1);
    repeat (9) cells.push_back('{31'h0100_0000, 32'sh0040_0000, -32'sh0020_0000});
    cells[4] = '{31'h7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000};
    cells[3] = '{31'h0000_0001, 32'sh8000_0000, 32'sh7FFF_FFFF};
    send_cells(cells);
    drain();

    // Linear closure, zero tau, zero density arriving below the center.
    write_reg(REG_RELAX_TIME, 0);
    write_reg(REG_LINEAR_CLOSURE, 1);
    cells.delete();
    repeat (9) cells.push_back('{31'h0200_0000, -32'sh0100_0000, 32'sh0100_0000});
    cells[7] = '{31'h0, 32'sh1234_5678, 32'sh0};
    send_cells(cells);
    drain();

    grid = 0;
    while (cells_sent < 1150 || tracker.results < 60) begin
      case (grid % 5)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 67; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 67; end
        3: begin send_idle_pct = 25; recv_stall_pct = 25; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      if ($urandom_range(0, 2) == 0) write_reg(REG_RELAX_TIME, $urandom());
      else if ($urandom_range(0, 1) == 0)
        write_reg(REG_RELAX_TIME, $urandom_range(32'h0080_0000, 32'h0300_0000));
      write_reg(REG_LINEAR_CLOSURE, $urandom_range(0, 1));
      random_grid($urandom_range(0, 6), $urandom_range(0, 4));
      grid++;
    end

    // Zero sizes, which clamp to a single interior cell.
    send_idle_pct = 25;
    recv_stall_pct = 25;
    write_reg(REG_RELAX_TIME, 32'h0100_0000);
    write_reg(REG_LINEAR_CLOSURE, 0);
    random_grid(0, 0);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.expected_flux.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+sv
sv/lftc_pkg.sv
sv/lftc_queue.sv
sv/lftc_front.sv
sv/lftc_div.sv
sv/lftc_back.sv
sv/lattice_flux_tensor_closure.sv
sv/lftc_checker.sv
test/tb.sv
